[sv/mbps_pkg.sv]
// Masked byte pattern scanner: shared types and constants.
// Used by the scanner top level and its checker; no dependencies.
package mbps_pkg;

  localparam int MAX_PAT   = 16;
  localparam int ADDR_BITS = 48;
  localparam int LEN_W     = $clog2(MAX_PAT + 1);
  localparam int IDX_W     = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3,
    REG_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [ADDR_BITS-1:0] byte_address;
    logic                 region_start;
    logic                 new_scan;
  } scan_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] match_address;
    logic [CNT_W-1:0]     match_number;
    logic                 limit_reached;
  } match_item_t;

endpackage

[sv/masked_byte_pattern_scanner_unit.sv]
// Masked byte pattern scanner top level: window, masked compare, match counter,
// result register with skid stage. Depends on mbps_pkg.
//
// Takes one byte per cycle while scan_stall is low; each match result is registered
// in the result register or, while a result waits there, in a one-entry skid stage,
// so the input keeps flowing. Bytes that complete no match give no transaction.
// scan_stall rises only when both hold a match, so a sustained stall downstream
// throttles the input once two matches are pending. The user writes configuration
// via the plain write port only while the block is idle; the block does not check.
module masked_byte_pattern_scanner_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            scan_valid,
  output logic                            scan_stall,
  input  mbps_pkg::scan_item_t            scan_item,
  output logic                            match_valid,
  input  logic                            match_stall,
  output mbps_pkg::match_item_t           match_item
);

  logic [63:0]                     pat_lo;
  logic [63:0]                     pat_hi;
  logic [mbps_pkg::MAX_PAT-1:0]    care_mask;
  logic [4:0]                      pattern_length;
  logic [mbps_pkg::CNT_W-1:0]      result_limit;

  logic [7:0]                      win [mbps_pkg::MAX_PAT-1];
  logic [mbps_pkg::LEN_W-1:0]      fill;
  logic [mbps_pkg::CNT_W-1:0]      match_count;
  logic                            scan_stopped;

  mbps_pkg::match_item_t           skid;
  logic                            skid_valid;

  logic                            accept;
  logic                            take;
  logic [7:0]                      wnew [mbps_pkg::MAX_PAT];
  logic [mbps_pkg::LEN_W-1:0]      len;
  logic [mbps_pkg::LEN_W-1:0]      fill_next;
  logic [mbps_pkg::CNT_W-1:0]      count_eff;
  logic [mbps_pkg::CNT_W-1:0]      count_next;
  logic [mbps_pkg::CNT_W-1:0]      limit;
  logic                            stopped_eff;
  logic                            miss;
  logic                            hit;
  logic                            at_limit;
  logic [127:0]                    pat;
  mbps_pkg::match_item_t           res;

  assign accept     = scan_valid && !scan_stall;
  assign take       = match_valid && !match_stall;
  assign scan_stall = skid_valid;
  assign pat        = {pat_hi, pat_lo};

  always_comb begin
    wnew[0] = scan_item.data_byte;
    for (int k = 1; k < mbps_pkg::MAX_PAT; k++) begin
      wnew[k] = win[k-1];
    end
  end

  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] fill_eff;
    logic [mbps_pkg::LEN_W-1:0] pos;
    if (pattern_length == 5'd0) begin
      len = mbps_pkg::LEN_W'(1);
    end else if (mbps_pkg::LEN_W'(pattern_length) > mbps_pkg::LEN_W'(mbps_pkg::MAX_PAT)
                 || 32'(pattern_length) > mbps_pkg::MAX_PAT) begin
      len = mbps_pkg::LEN_W'(mbps_pkg::MAX_PAT);
    end else begin
      len = mbps_pkg::LEN_W'(pattern_length);
    end

    fill_eff  = scan_item.region_start ? '0 : fill;
    fill_next = (fill_eff < mbps_pkg::LEN_W'(mbps_pkg::MAX_PAT)) ?
                fill_eff + mbps_pkg::LEN_W'(1) : fill_eff;

    count_eff   = scan_item.new_scan ? '0 : match_count;
    stopped_eff = scan_item.new_scan ? 1'b0 : scan_stopped;

    miss = 1'b0;
    for (int i = 0; i < mbps_pkg::MAX_PAT; i++) begin
      pos = len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
      if (mbps_pkg::LEN_W'(i) < len && care_mask[i] &&
          wnew[pos[mbps_pkg::IDX_W-1:0]] != pat[8*i +: 8]) begin
        miss = 1'b1;
      end
    end

    hit        = (fill_next >= len) && !stopped_eff && !miss;
    limit      = (result_limit == '0) ? mbps_pkg::CNT_W'(1) : result_limit;
    count_next = count_eff + mbps_pkg::CNT_W'(1);
    at_limit   = (count_next >= limit) || (count_next == '1);

    res.match_address = scan_item.byte_address
                        - mbps_pkg::ADDR_BITS'(len - mbps_pkg::LEN_W'(1));
    res.match_number  = count_next;
    res.limit_reached = at_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo         <= '0;
      pat_hi         <= '0;
      care_mask      <= '1;
      pattern_length <= 5'd1;
      result_limit   <= mbps_pkg::CNT_W'(1);
      fill           <= '0;
      match_count    <= '0;
      scan_stopped   <= 1'b0;
      match_valid    <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          mbps_pkg::REG_PAT_LO: pat_lo         <= cfg_data;
          mbps_pkg::REG_PAT_HI: pat_hi         <= cfg_data;
          mbps_pkg::REG_CARE:   care_mask      <= cfg_data[mbps_pkg::MAX_PAT-1:0];
          mbps_pkg::REG_LEN:    pattern_length <= cfg_data[4:0];
          mbps_pkg::REG_LIMIT:  result_limit   <= cfg_data[mbps_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        fill         <= fill_next;
        match_count  <= hit ? count_next : count_eff;
        scan_stopped <= stopped_eff || (hit && at_limit);
      end

      if (!match_valid || take) begin
        if (skid_valid) begin
          match_valid <= 1'b1;
          skid_valid  <= 1'b0;
        end else begin
          match_valid <= accept && hit;
        end
      end else if (accept && hit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= scan_item.data_byte;
      for (int k = 1; k < mbps_pkg::MAX_PAT - 1; k++) begin
        win[k] <= win[k-1];
      end
    end
    if (!match_valid || take) begin
      match_item <= skid_valid ? skid : res;
    end else if (accept && hit) begin
      skid <= res;
    end
  end

endmodule

[sv/mbps_checker.sv]
// Port-level checker for the masked byte pattern scanner and its bind.
// Depends on mbps_pkg and masked_byte_pattern_scanner_unit.
module mbps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            scan_stall,
  input logic                            match_valid,
  input logic                            match_stall,
  input mbps_pkg::match_item_t           match_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    match_valid && match_stall |=> match_valid && $stable(match_item))
    else $error("stalled match transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !match_valid && !scan_stall)
    else $error("output not empty after reset");

  a_number: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> match_item.match_number != '0)
    else $error("match number zero");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    scan_stall |-> match_valid)
    else $error("input stalled with empty output");

endmodule

bind masked_byte_pattern_scanner_unit mbps_checker u_mbps_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for masked_byte_pattern_scanner_unit: directed and random byte streams,
// checked against a cycle-free model of the masked window compare. Depends on mbps_pkg.
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbps_pkg::CFG_W-1:0]     cfg_data = '0;
  logic        scan_valid = 1'b0;
  logic        scan_stall;
  mbps_pkg::scan_item_t  scan_item = '0;
  logic        match_valid;
  logic        match_stall = 1'b0;
  mbps_pkg::match_item_t match_item;

  masked_byte_pattern_scanner_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .scan_valid(scan_valid),
    .scan_stall(scan_stall),
    .scan_item(scan_item),
    .match_valid(match_valid),
    .match_stall(match_stall),
    .match_item(match_item)
  );

  always #5 clk = ~clk;

  // scanner model state
  bit [63:0] pat_lo_m, pat_hi_m;
  bit [15:0] care_m, limit_m;
  bit [4:0]  plen_m;
  bit [7:0]  win_m [mbps_pkg::MAX_PAT];
  int        fill_m;
  bit [15:0] count_m;
  bit        stopped_m;

  mbps_pkg::match_item_t expected_matches [$];
  int errors = 0;
  int bytes_sent = 0;
  int matches_seen = 0;
  int settings_used = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  int stall_left = 0;

  // random stream bookkeeping
  bit [mbps_pkg::ADDR_BITS-1:0] cur_addr;
  bit pending_region, pending_scan;

  function automatic int eff_len();
    if (plen_m == 0) return 1;
    if (plen_m > mbps_pkg::MAX_PAT) return mbps_pkg::MAX_PAT;
    return plen_m;
  endfunction

  function automatic bit [7:0] pat_byte(int i);
    return (i < 8) ? pat_lo_m[8*i +: 8] : pat_hi_m[8*(i-8) +: 8];
  endfunction

  function automatic bit predict_match(input mbps_pkg::scan_item_t it,
                                       output mbps_pkg::match_item_t res);
    int len;
    bit hit;
    bit [15:0] lim;
    res = '0;
    if (it.new_scan) begin
      count_m = '0;
      stopped_m = 0;
    end
    if (it.region_start) fill_m = 0;
    for (int k = mbps_pkg::MAX_PAT - 1; k > 0; k--) win_m[k] = win_m[k-1];
    win_m[0] = it.data_byte;
    if (fill_m < mbps_pkg::MAX_PAT) fill_m++;
    len = eff_len();
    if (fill_m < len || stopped_m) return 0;
    hit = 1;
    for (int i = 0; i < len; i++)
      if (care_m[i] && win_m[len-1-i] != pat_byte(i)) hit = 0;
    if (!hit) return 0;
    lim = (limit_m == 0) ? 16'd1 : limit_m;
    count_m++;
    res.match_address = it.byte_address - mbps_pkg::ADDR_BITS'(len - 1);
    res.match_number = count_m;
    res.limit_reached = (count_m >= lim) || (count_m == 16'hFFFF);
    if (res.limit_reached) stopped_m = 1;
    return 1;
  endfunction

  // result checker and input monitor
  always @(posedge clk) begin
    mbps_pkg::match_item_t exp_m, pred;
    if (!rst) begin
      if (match_valid && !match_stall) begin
        matches_seen++;
        stall_left = out_idle ? $urandom_range(0, 17) : 0;
        if (expected_matches.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected match %p", match_item);
        end else begin
          exp_m = expected_matches.pop_front();
          if (match_item.match_address !== exp_m.match_address ||
              match_item.match_number !== exp_m.match_number ||
              match_item.limit_reached !== exp_m.limit_reached) begin
            errors++;
            if (errors <= 10)
              $display({"ERROR: match mismatch exp addr=%h num=%0d lim=%b",
                        " got addr=%h num=%0d lim=%b"},
                       exp_m.match_address, exp_m.match_number, exp_m.limit_reached,
                       match_item.match_address, match_item.match_number,
                       match_item.limit_reached);
          end
        end
      end
      if (scan_valid && !scan_stall)
        if (predict_match(scan_item, pred))
          expected_matches.insert(expected_matches.size(), pred);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      match_stall = 1'b1;
      stall_left--;
    end else begin
      match_stall = 1'b0;
    end
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic mbps_pkg::scan_item_t mk_item(bit [7:0] b,
                                                   bit [mbps_pkg::ADDR_BITS-1:0] a,
                                                   bit rs, bit ns);
    mbps_pkg::scan_item_t it;
    it.data_byte = b;
    it.byte_address = a;
    it.region_start = rs;
    it.new_scan = ns;
    return it;
  endfunction

  task automatic send_item(input mbps_pkg::scan_item_t it);
    int gap;
    gap = in_idle ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      scan_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    scan_item = it;
    scan_valid = 1'b1;
    do @(posedge clk); while (scan_stall);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    scan_valid = 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input mbps_pkg::cfg_reg_t idx, input bit [63:0] val);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      mbps_pkg::REG_PAT_LO: pat_lo_m = val;
      mbps_pkg::REG_PAT_HI: pat_hi_m = val;
      mbps_pkg::REG_CARE:   care_m = val[15:0];
      mbps_pkg::REG_LEN:    plen_m = val[4:0];
      mbps_pkg::REG_LIMIT:  limit_m = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic set_config(bit [63:0] lo, bit [63:0] hi, bit [15:0] care,
                            bit [4:0] len, bit [15:0] lim);
    write_reg(mbps_pkg::REG_PAT_LO, lo);
    write_reg(mbps_pkg::REG_PAT_HI, hi);
    write_reg(mbps_pkg::REG_CARE, {48'd0, care});
    write_reg(mbps_pkg::REG_LEN, {59'd0, len});
    write_reg(mbps_pkg::REG_LIMIT, {48'd0, lim});
    settings_used++;
  endtask

  // defaults: one-byte pattern 0x00, first match only
  task automatic test_reset_values();
    send_item(mk_item(8'h00, '0, 1, 1));
    send_item(mk_item(8'h00, 48'd1, 0, 0));
    send_item(mk_item(8'hFF, '1, 1, 1));
    send_item(mk_item(8'h00, '1, 0, 1));
    wait_idle();
  endtask

  // pattern FF ?? 80, limit two per scan
  task automatic test_masked_match();
    set_config(64'h0000_0000_0080_00FF, '1, 16'h0005, 5'd3, 16'd2);
    send_item(mk_item(8'hFF, 48'd1, 1, 1));
    send_item(mk_item(8'h37, 48'd2, 0, 0));
    send_item(mk_item(8'h80, 48'd3, 0, 0));
    send_item(mk_item(8'hFF, 48'd4, 0, 0));
    send_item(mk_item(8'h00, 48'd5, 0, 0));
    send_item(mk_item(8'h80, 48'd6, 0, 0));
    send_item(mk_item(8'hFF, 48'd7, 0, 0));
    send_item(mk_item(8'hC3, 48'd8, 0, 0));
    send_item(mk_item(8'h80, 48'd9, 0, 0));
    wait_idle();
  endtask

  // region restart mid pattern, then a window that wraps the address space
  task automatic test_region_and_wrap();
    send_item(mk_item(8'hFF, 48'd20, 1, 1));
    send_item(mk_item(8'h00, 48'd21, 0, 0));
    send_item(mk_item(8'h80, 48'd50, 1, 0));
    send_item(mk_item(8'hFF, '1, 1, 1));
    send_item(mk_item(8'h5A, 48'd0, 0, 0));
    send_item(mk_item(8'h80, 48'd1, 0, 0));
    wait_idle();
  endtask

  task automatic test_limit_change();
    write_reg(mbps_pkg::REG_LIMIT, 64'd5);
    send_item(mk_item(8'hFF, 48'h100, 1, 1));
    send_item(mk_item(8'h11, 48'h101, 0, 0));
    send_item(mk_item(8'h80, 48'h102, 0, 0));
    wait_idle();
    write_reg(mbps_pkg::REG_LIMIT, 64'd1);
    send_item(mk_item(8'hFF, 48'h103, 0, 0));
    send_item(mk_item(8'h22, 48'h104, 0, 0));
    send_item(mk_item(8'h80, 48'h105, 0, 0));
    wait_idle();
  endtask

  // length 0 acts as 1, all wildcards, limit 0 acts as 1
  task automatic test_length_extremes();
    set_config('0, '0, 16'h0000, 5'd0, 16'd0);
    send_item(mk_item(8'hA5, 48'h7FFF_0000_0000, 1, 1));
    send_item(mk_item(8'h5A, 48'h7FFF_0000_0001, 0, 0));
    wait_idle();
  endtask

  task automatic emit(input bit [7:0] b);
    send_item(mk_item(b, cur_addr, pending_region, pending_scan));
    pending_region = 0;
    pending_scan = 0;
    cur_addr++;
  endtask

  task automatic start_region();
    cur_addr = ($urandom_range(0, 3) == 0) ?
               ('1 - mbps_pkg::ADDR_BITS'($urandom_range(0, 20))) :
               mbps_pkg::ADDR_BITS'({$urandom, $urandom});
    pending_region = 1;
  endtask

  task automatic emit_pattern(input bit corrupt);
    int len, bad;
    bit [7:0] b;
    len = eff_len();
    bad = corrupt ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      b = care_m[i] ? pat_byte(i) : 8'($urandom);
      if (i == bad) b ^= 8'($urandom_range(1, 255));
      emit(b);
    end
  endtask

  task automatic random_config(int phase);
    bit [4:0] len;
    bit [15:0] care, lim;
    bit [63:0] lo, hi;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: len = 5'd0;
      1: len = 5'($urandom_range(17, 31));
      2: len = 5'd16;
      default: len = 5'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 4))
      0: care = 16'h0000;
      1: care = 16'hFFFF;
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: lim = 16'($urandom_range(1, 4));
      1: lim = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: lim = 16'($urandom_range(5, 65535));
    endcase
    if (phase == 0) begin
      lo = '1; hi = '1; care = 16'hFFFF; len = 5'd16; lim = 16'hFFFF;
    end else if (phase == 1) begin
      lo = '0; hi = '0; care = 16'hFFFF; len = 5'd31; lim = 16'd3;
    end
    set_config(lo, hi, care, len, lim);
  endtask

  task automatic test_random_scans();
    int target;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      random_config(phase);
      in_idle = (phase > 1) && $urandom_range(0, 2) != 0;
      out_idle = (phase > 1) && $urandom_range(0, 2) != 0;
      start_region();
      pending_scan = 1;
      target = bytes_sent + 60;
      while (bytes_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: emit_pattern(0);
          4, 5: emit_pattern($urandom_range(0, 1));
          6, 7: repeat ($urandom_range(1, 4)) emit(8'($urandom));
          8: start_region();
          default: pending_scan = 1;
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin
    pat_lo_m = '0;
    pat_hi_m = '0;
    care_m = 16'hFFFF;
    plen_m = 5'd1;
    limit_m = 16'd1;
    foreach (win_m[k]) win_m[k] = '0;
    fill_m = 0;
    count_m = '0;
    stopped_m = 0;
    cur_addr = '0;
    pending_region = 0;
    pending_scan = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_masked_match();
    test_region_and_wrap();
    test_limit_change();
    test_length_extremes();
    test_random_scans();

    repeat (10) @(posedge clk);
    if (expected_matches.size() != 0) begin
      errors++;
      $display("ERROR: %0d matches never arrived", expected_matches.size());
    end
    $display("Scanned %0d bytes under %0d register settings, %0d matches checked.",
             bytes_sent, settings_used, matches_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
sv/mbps_pkg.sv
sv/masked_byte_pattern_scanner_unit.sv
sv/mbps_checker.sv
sim/testbench.sv
